// File: hdl/gcdlcm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gcdlcm_pkg: shared types and constants for the gcd/lcm unit
// Widths, commands, controller states and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package gcdlcm_pkg;
  localparam int unsigned OpW = 63;
  localparam int unsigned CntW = 6;
  localparam logic [OpW-1:0] PosMax = {OpW{1'b1}};

  typedef enum logic {
    CMD_GCD = 1'b0,
    CMD_LCM = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SWAP,
    ST_QDIV,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic swap;
    logic qdiv_start;
    logic mul_start;
    logic mul_step;
    logic fin_gcd;
    logic fin_lcm;
    logic fin_zero;
  } ctrl_t;

  typedef struct packed {
    logic y_zero;
    logic any_zero;
    logic step_last;
    logic is_lcm;
  } stat_t;

  function automatic logic [OpW-1:0] sat_mag(input logic [OpW:0] v);
    logic [OpW:0] n;
    begin
      n = ~v + 1'b1;
      if (v == {1'b1, {OpW{1'b0}}}) sat_mag = PosMax;
      else if (v[OpW]) sat_mag = n[OpW-1:0];
      else sat_mag = v[OpW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// File: hdl/gcdlcm_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gcdlcm_dp: gcd/lcm datapath
// Radix-2 restoring divider (one bit a cycle), Euclid operand registers and
// a shift-add multiplier with overflow detection.
// ---------------------------------------------------------------------------
module gcdlcm_dp
  import gcdlcm_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire logic         in_cmd,
  input  wire logic [OpW:0] in_a,
  input  wire logic [OpW:0] in_b,
  input  wire ctrl_t        ctrl,
  output stat_t             stat,
  output logic [OpW-1:0]    res,
  output logic              sat
);
  logic [OpW-1:0] x_r, x_nxt, y_r, y_nxt, ma_r, ma_nxt, mb_r, mb_nxt;
  logic [OpW-1:0] rem_r, rem_nxt, quo_r, quo_nxt, div_d_r, div_d_nxt;
  logic [OpW-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt, mplier_r, mplier_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt, cmd_r, cmd_nxt;
  logic [OpW-1:0] res_r, res_nxt;
  logic sat_r, sat_nxt;
  logic [OpW:0] trial, sum;
  logic [OpW-1:0] shifted;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; ma_nxt = ma_r; mb_nxt = mb_r;
    rem_nxt = rem_r; quo_nxt = quo_r; div_d_nxt = div_d_r;
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplier_nxt = mplier_r;
    cnt_nxt = cnt_r; ovf_nxt = ovf_r; cmd_nxt = cmd_r;
    res_nxt = res_r; sat_nxt = sat_r;
    trial = {rem_r, quo_r[OpW-1]} - {1'b0, div_d_r};
    sum = {1'b0, acc_r} + {1'b0, mcand_r};
    shifted = {mcand_r[OpW-2:0], 1'b0};
    if (ctrl.load) begin
      x_nxt = sat_mag(in_a); y_nxt = sat_mag(in_b);
      ma_nxt = sat_mag(in_a); mb_nxt = sat_mag(in_b);
      cmd_nxt = in_cmd;
    end
    if (ctrl.div_start || ctrl.qdiv_start) begin
      rem_nxt = '0;
      quo_nxt = ctrl.div_start ? x_r : ma_r;
      div_d_nxt = ctrl.div_start ? y_r : x_r;
      cnt_nxt = CntW'(OpW - 1);
    end
    if (ctrl.div_step) begin
      if (!trial[OpW]) begin
        rem_nxt = trial[OpW-1:0];
        quo_nxt = {quo_r[OpW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[OpW-2:0], quo_r[OpW-1]};
        quo_nxt = {quo_r[OpW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
    if (ctrl.swap) begin
      x_nxt = y_r; y_nxt = rem_r;
    end
    if (ctrl.mul_start) begin
      acc_nxt = '0; mcand_nxt = quo_nxt; mplier_nxt = mb_r; ovf_nxt = 1'b0;
      cnt_nxt = CntW'(OpW - 1);
    end
    if (ctrl.mul_step) begin
      if (mplier_r[0]) begin
        acc_nxt = sum[OpW-1:0];
        if (sum[OpW]) ovf_nxt = 1'b1;
      end
      mcand_nxt = shifted;
      if (mcand_r[OpW-1] && (mplier_r[OpW-1:1] != '0)) ovf_nxt = 1'b1;
      mplier_nxt = {1'b0, mplier_r[OpW-1:1]};
      cnt_nxt = cnt_r - 1'b1;
    end
    if (ctrl.fin_gcd) begin
      res_nxt = x_r; sat_nxt = 1'b0;
    end
    if (ctrl.fin_zero) begin
      res_nxt = '0; sat_nxt = 1'b0;
    end
    if (ctrl.fin_lcm) begin
      res_nxt = ovf_nxt ? PosMax : acc_nxt; sat_nxt = ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; ma_r <= ma_nxt; mb_r <= mb_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; div_d_r <= div_d_nxt;
    acc_r <= acc_nxt; mcand_r <= mcand_nxt; mplier_r <= mplier_nxt;
    ovf_r <= ovf_nxt; cmd_r <= cmd_nxt; res_r <= res_nxt; sat_r <= sat_nxt;
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  assign stat.y_zero = (y_r == '0);
  assign stat.any_zero = (ma_r == '0) || (mb_r == '0);
  assign stat.step_last = (cnt_r == '0);
  assign stat.is_lcm = (cmd_r == CMD_LCM);
  assign res = res_r;
  assign sat = sat_r;
endmodule
`default_nettype wire

// File: hdl/gcdlcm_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gcdlcm_ctrl: gcd/lcm controller
// Sequences load, Euclid divisions, quotient division, multiply and output.
// ---------------------------------------------------------------------------
module gcdlcm_ctrl
  import gcdlcm_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire logic   in_fire,
  input  wire logic   out_fire,
  input  wire stat_t  stat,
  output ctrl_t       ctrl,
  output logic        busy,
  output logic        out_valid
);
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (stat.is_lcm && stat.any_zero) state_nxt = ST_DONE;
        else if (stat.y_zero) state_nxt = stat.is_lcm ? ST_QDIV : ST_DONE;
        else state_nxt = ST_DIV;
      end
      ST_DIV:   if (stat.step_last) state_nxt = ST_SWAP;
      ST_SWAP:  state_nxt = ST_CHECK;
      ST_QDIV:  if (stat.step_last) state_nxt = ST_MUL;
      ST_MUL:   if (stat.step_last) state_nxt = ST_DONE;
      ST_DONE:  if (out_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE:  ctrl.load = in_fire;
      ST_CHECK: begin
        if (stat.is_lcm && stat.any_zero) ctrl.fin_zero = 1'b1;
        else if (stat.y_zero) begin
          ctrl.fin_gcd = !stat.is_lcm;
          ctrl.qdiv_start = stat.is_lcm;
        end else ctrl.div_start = 1'b1;
      end
      ST_DIV:   begin
        ctrl.div_step = 1'b1;
      end
      ST_SWAP:  ctrl.swap = 1'b1;
      ST_QDIV:  begin
        ctrl.div_step = 1'b1;
        ctrl.mul_start = stat.step_last;
      end
      ST_MUL:   begin
        ctrl.mul_step = 1'b1;
        ctrl.fin_lcm = stat.step_last;
      end
      default:  ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
endmodule
`default_nettype wire

// File: hdl/gcd_lcm_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gcd_lcm_unit: 64-bit signed gcd / lcm
// Takes one command beat, returns one result beat, one item at a time.
// ---------------------------------------------------------------------------
// An item runs a check, a bit-serial division and a swap per Euclid
// remainder step (one divider shared by all divisions); lcm adds one more
// division and a shift-add multiply. Zero operands for lcm go from the check
// straight to the result. The input is ready only while no item is in flight.
module gcd_lcm_unit
  import gcdlcm_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire [127:0]  s_axis_tdata,  // [63:0] operand_a, [127:64] operand_b
  input  wire          s_axis_tuser,  // [0] cmd
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [63:0]  m_axis_tdata   // [62:0] result, [63] saturated
);
  ctrl_t ctrl;
  stat_t stat;
  logic busy, in_fire, out_fire, sat;
  logic [OpW-1:0] res;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  gcdlcm_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .stat, .ctrl, .busy,
    .out_valid(m_axis_tvalid)
  );

  gcdlcm_dp u_dp (
    .clk, .rst_n, .in_cmd(s_axis_tuser), .in_a(s_axis_tdata[63:0]),
    .in_b(s_axis_tdata[127:64]), .ctrl, .stat, .res, .sat
  );

  assign m_axis_tdata = {sat, res};

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[63] |-> m_axis_tdata[62:0] == PosMax)
    else $error("saturated result not clamped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("accepting while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule
`default_nettype wire
